@@ rtl/core/icp_pkg.sv @@
// shared types, codes and decode functions for the infix to postfix converter
`timescale 1ns / 1ps

package icp_pkg;

   localparam int DEFAULT_STACK_DEPTH = 32;

   localparam logic [7:0] CHAR_LPAREN = 8'h28;
   localparam logic [7:0] CHAR_RPAREN = 8'h29;
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_SLASH  = 8'h2F;
   localparam logic [7:0] CHAR_CARET  = 8'h5E;
   localparam logic [7:0] CHAR_LO_A   = 8'h61;
   localparam logic [7:0] CHAR_LO_Z   = 8'h7A;
   localparam logic [7:0] CHAR_UP_A   = 8'h41;
   localparam logic [7:0] CHAR_UP_Z   = 8'h5A;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_NUL    = 8'h00;

   typedef logic [2:0] op_code_type;
   typedef logic [1:0] prec_type;

   localparam op_code_type CODE_NONE   = 3'd0;
   localparam op_code_type CODE_LPAREN = 3'd1;
   localparam op_code_type CODE_PLUS   = 3'd2;
   localparam op_code_type CODE_MINUS  = 3'd3;
   localparam op_code_type CODE_STAR   = 3'd4;
   localparam op_code_type CODE_SLASH  = 3'd5;
   localparam op_code_type CODE_CARET  = 3'd6;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROC,
      ST_FLUSH
   } state_type;

   typedef enum logic [1:0] {
      EMIT_INPUT,
      EMIT_TOP,
      EMIT_TERM
   } emit_sel_type;

   typedef struct packed {
      logic         load;
      logic         emit;
      emit_sel_type emit_sel;
      logic         push;
      logic         pop;
      logic         clr_ovf;
   } cmd_type;

   typedef struct packed {
      logic is_operand;
      logic is_rparen;
      logic is_push;
      logic last;
      logic empty;
      logic top_lparen;
      logic top_pops;
      logic out_free;
   } stat_type;

   function automatic op_code_type char_code(input logic [7:0] c);
      op_code_type r;
      unique case (c)
         CHAR_LPAREN: r = CODE_LPAREN;
         CHAR_PLUS:   r = CODE_PLUS;
         CHAR_MINUS:  r = CODE_MINUS;
         CHAR_STAR:   r = CODE_STAR;
         CHAR_SLASH:  r = CODE_SLASH;
         CHAR_CARET:  r = CODE_CARET;
         default:     r = CODE_NONE;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] code_char(input op_code_type code);
      logic [7:0] r;
      unique case (code)
         CODE_LPAREN: r = CHAR_LPAREN;
         CODE_PLUS:   r = CHAR_PLUS;
         CODE_MINUS:  r = CHAR_MINUS;
         CODE_STAR:   r = CHAR_STAR;
         CODE_SLASH:  r = CHAR_SLASH;
         CODE_CARET:  r = CHAR_CARET;
         default:     r = CHAR_NUL;
      endcase
      return r;
   endfunction

   function automatic prec_type code_prec(input op_code_type code);
      prec_type r;
      unique case (code)
         CODE_PLUS, CODE_MINUS: r = 2'd1;
         CODE_STAR, CODE_SLASH: r = 2'd2;
         CODE_CARET:            r = 2'd3;
         default:               r = 2'd0;
      endcase
      return r;
   endfunction

   function automatic logic is_operand(input logic [7:0] c);
      return (c >= CHAR_LO_A && c <= CHAR_LO_Z) || (c >= CHAR_UP_A && c <= CHAR_UP_Z) ||
             (c >= CHAR_ZERO && c <= CHAR_NINE);
   endfunction

endpackage

@@ rtl/core/infix_to_postfix_converter_core.sv @@
// top level of the infix to postfix converter: controller plus stack datapath
//
// Usage: infix characters enter on the req_ channel (req_in_char, req_in_last), one item
// per handshake; postfix characters leave on the rsp_ channel. An item is taken when
// valid is high and stall is low. Operands pass through, operators and parentheses
// go through an operator stack held in a memory of STACK_DEPTH entries.
// The block takes no new item until it is through with the last one. The pop loop of
// the controller emits one result per cycle while the output register is free. With
// req_in_last set the stack is flushed, operators emitted and left parentheses
// dropped, then the NUL terminator follows with rsp_out_last high. rsp_overflow is the
// sticky flag of dropped pushes in this expression; it is cleared after the terminator.
// A result is registered in the output register in the cycle after it is decided; an
// operand is first loaded into the input holding register and then decided in ST_PROC.
// Reset: the stack is empty and the flag is clear at once, with no clearing pass.
// When the receiver stalls, the result is held and the controller waits; req_stall
// stays high while an item is being worked on.
`timescale 1ns / 1ps

module infix_to_postfix_converter_core #(
   parameter int STACK_DEPTH = icp_pkg::DEFAULT_STACK_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_char,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_out_last,
   output logic       rsp_overflow
);
   import icp_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   icp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   icp_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_in_char  (req_in_char),
      .req_in_last  (req_in_last),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_char (rsp_out_char),
      .rsp_out_last (rsp_out_last),
      .rsp_overflow (rsp_overflow)
   );

endmodule

@@ rtl/core/icp_datapath.sv @@
// operator stack, input holding register and output register of the converter
`timescale 1ns / 1ps

module icp_datapath #(
   parameter int STACK_DEPTH = icp_pkg::DEFAULT_STACK_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  icp_pkg::cmd_type  cmd,
   output icp_pkg::stat_type stat,
   input  logic [7:0]        req_in_char,
   input  logic              req_in_last,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_out_char,
   output logic              rsp_out_last,
   output logic              rsp_overflow
);
   import icp_pkg::*;

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int AW    = $clog2(STACK_DEPTH);

   op_code_type      stack_mem [STACK_DEPTH];
   op_code_type      top_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] rd_cnt;
   logic             ovf_ff, ovf_in;
   logic [7:0]       ch_ff;
   logic             last_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_char_ff, rsp_char_in;
   logic             rsp_last_ff;
   logic             rsp_ovf_ff;
   logic             full, empty, push_ok;
   op_code_type      in_code;
   prec_type         in_prec, top_prec;

   assign in_code  = char_code(ch_ff);
   assign in_prec  = code_prec(in_code);
   assign top_prec = code_prec(top_ff);
   assign full     = (count_ff == CNT_W'(STACK_DEPTH));
   assign empty    = (count_ff == '0);
   assign push_ok  = cmd.push && !full;

   always_comb begin
      count_in = count_ff;
      if (push_ok) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.pop && !empty) begin
         count_in = count_ff - 1'b1;
      end
      rd_cnt = count_in - 1'b1;
      ovf_in = ovf_ff;
      if (cmd.push && full) begin
         ovf_in = 1'b1;
      end else if (cmd.clr_ovf) begin
         ovf_in = 1'b0;
      end
   end

   // top of stack kept in a registered read, bypassed on a push
   always_ff @(posedge clock) begin
      if (push_ok) begin
         stack_mem[count_ff[AW-1:0]] <= in_code;
      end
      if (push_ok) begin
         top_ff <= in_code;
      end else if (count_in != '0) begin
         top_ff <= stack_mem[rd_cnt[AW-1:0]];
      end else begin
         top_ff <= CODE_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ch_ff   <= req_in_char;
         last_ff <= req_in_last;
      end
   end

   always_comb begin
      case (cmd.emit_sel)
         EMIT_INPUT: rsp_char_in = ch_ff;
         EMIT_TOP:   rsp_char_in = code_char(top_ff);
         default:    rsp_char_in = CHAR_NUL;
      endcase
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_char_ff <= rsp_char_in;
         rsp_last_ff <= (cmd.emit_sel == EMIT_TERM);
         rsp_ovf_ff  <= ovf_ff;
      end
   end

   always_comb begin
      stat.is_operand = is_operand(ch_ff);
      stat.is_rparen  = (ch_ff == CHAR_RPAREN);
      stat.is_push    = (in_code != CODE_NONE);
      stat.last       = last_ff;
      stat.empty      = empty;
      stat.top_lparen = (top_ff == CODE_LPAREN);
      stat.top_pops   = !empty && in_code != CODE_LPAREN &&
                        top_ff != CODE_LPAREN && top_ff != CODE_NONE &&
                        (top_prec > in_prec ||
                         (top_prec == in_prec && ch_ff != CHAR_CARET));
      stat.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_char = rsp_char_ff;
   assign rsp_out_last = rsp_last_ff;
   assign rsp_overflow = rsp_ovf_ff;

endmodule

@@ rtl/core/icp_ctrl.sv @@
// controller state machine sequencing pops, pushes and the end of expression flush
`timescale 1ns / 1ps

module icp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  icp_pkg::stat_type stat,
   output icp_pkg::cmd_type  cmd
);
   import icp_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.emit_sel = EMIT_INPUT;
      req_stall    = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_PROC;
            end
         end
         ST_PROC: begin
            if (stat.is_operand) begin
               if (stat.out_free) begin
                  cmd.emit = 1'b1;
                  state_in = stat.last ? ST_FLUSH : ST_IDLE;
               end
            end else if (stat.is_rparen) begin
               if (!stat.empty && !stat.top_lparen) begin
                  if (stat.out_free) begin
                     cmd.emit     = 1'b1;
                     cmd.emit_sel = EMIT_TOP;
                     cmd.pop      = 1'b1;
                  end
               end else begin
                  cmd.pop  = 1'b1;
                  state_in = stat.last ? ST_FLUSH : ST_IDLE;
               end
            end else if (stat.is_push) begin
               if (stat.top_pops) begin
                  if (stat.out_free) begin
                     cmd.emit     = 1'b1;
                     cmd.emit_sel = EMIT_TOP;
                     cmd.pop      = 1'b1;
                  end
               end else begin
                  cmd.push = 1'b1;
                  state_in = stat.last ? ST_FLUSH : ST_IDLE;
               end
            end else begin
               state_in = stat.last ? ST_FLUSH : ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (!stat.empty) begin
               if (stat.top_lparen) begin
                  cmd.pop = 1'b1;
               end else if (stat.out_free) begin
                  cmd.emit     = 1'b1;
                  cmd.emit_sel = EMIT_TOP;
                  cmd.pop      = 1'b1;
               end
            end else if (stat.out_free) begin
               cmd.emit     = 1'b1;
               cmd.emit_sel = EMIT_TERM;
               cmd.clr_ovf  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ tb/tb.sv @@
// self-checking testbench for the infix to postfix converter core
`timescale 1ns / 1ps

module tb;
   import icp_pkg::*;

   localparam int STK_DEPTH      = DEFAULT_STACK_DEPTH;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 16;
   localparam int RANDOM_ITEMS   = 190;
   localparam int MAX_REPORTS    = 10;

   localparam int EXPR_WELL   = 0;
   localparam int EXPR_DEEP   = 1;
   localparam int EXPR_BROKEN = 2;

   localparam int DEEP_CARET  = 0;
   localparam int DEEP_NESTED = 1;

   localparam int RX_FREE  = 0;
   localparam int RX_LIGHT = 1;
   localparam int RX_HEAVY = 2;
   localparam int RX_BEAT  = 3;

   localparam logic [7:0] GLYPH [8] = '{CHAR_NUL, CHAR_LPAREN, CHAR_PLUS, CHAR_MINUS,
                                        CHAR_STAR, CHAR_SLASH, CHAR_CARET, CHAR_NUL};
   localparam int RANK [8] = '{0, 0, 1, 1, 2, 2, 3, 0};

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic       ovf;
   } postfix_char_type;

   typedef struct packed {
      logic [7:0]       ch;
      logic             last;
      logic             typed;
      logic             nres;
      postfix_char_type r;
   } stim_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [7:0] req_in_char;
   logic req_in_last;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [7:0] rsp_out_char;
   logic rsp_out_last;
   logic rsp_overflow;

   stim_type cur_item = '0;
   logic long_hold_req = 1'b0;

   // predictor state
   op_code_type opstk [STK_DEPTH];
   int opcnt = 0;
   logic ovf_seen = 1'b0;

   postfix_char_type postfix_q [$];
   postfix_char_type step_res [$];
   postfix_char_type want;

   int err_cnt = 0;
   int items_in = 0;
   int chars_out = 0;
   int exprs_done = 0;
   int ovf_terms = 0;
   int burst_left = 0;
   int idle_cycles = 0;

   int rx_mode = RX_FREE;
   int rx_left = 0;
   int rx_tick = 0;
   int hold_cnt = 0;
   bit hold_taken = 1'b0;

   stim_type dir_tab [26];

   assign req_in_char = cur_item.ch;
   assign req_in_last = cur_item.last;

   infix_to_postfix_converter_core u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_char  (req_in_char),
      .req_in_last  (req_in_last),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_char (rsp_out_char),
      .rsp_out_last (rsp_out_last),
      .rsp_overflow (rsp_overflow)
   );

   always #4 clock = ~clock;

   function automatic op_code_type op_of(input logic [7:0] ch);
      case (ch)
         CHAR_LPAREN: return CODE_LPAREN;
         CHAR_PLUS:   return CODE_PLUS;
         CHAR_MINUS:  return CODE_MINUS;
         CHAR_STAR:   return CODE_STAR;
         CHAR_SLASH:  return CODE_SLASH;
         CHAR_CARET:  return CODE_CARET;
         default:     return CODE_NONE;
      endcase
   endfunction

   function automatic bit is_alnum(input logic [7:0] ch);
      return (ch >= CHAR_LO_A && ch <= CHAR_LO_Z) || (ch >= CHAR_UP_A && ch <= CHAR_UP_Z) ||
             (ch >= CHAR_ZERO && ch <= CHAR_NINE);
   endfunction

   // one character through the operator stack
   function automatic void shunt_char(input logic [7:0] ch, input logic last,
                                      ref postfix_char_type res [$]);
      op_code_type code;
      op_code_type top;
      res = {};
      code = op_of(ch);
      if (is_alnum(ch)) begin
         res.push_back('{ch, 1'b0, ovf_seen});
      end else if (ch == CHAR_RPAREN) begin
         while (opcnt > 0 && opstk[opcnt-1] != CODE_LPAREN) begin
            res.push_back('{GLYPH[opstk[opcnt-1]], 1'b0, ovf_seen});
            opcnt--;
         end
         if (opcnt > 0) opcnt--;
      end else if (code != CODE_NONE) begin
         if (code != CODE_LPAREN) begin
            while (opcnt > 0) begin
               top = opstk[opcnt-1];
               if (top == CODE_LPAREN) break;
               if (RANK[top] > RANK[code] ||
                   (RANK[top] == RANK[code] && code != CODE_CARET)) begin
                  res.push_back('{GLYPH[top], 1'b0, ovf_seen});
                  opcnt--;
               end else begin
                  break;
               end
            end
         end
         if (opcnt >= STK_DEPTH) ovf_seen = 1'b1;
         else begin
            opstk[opcnt] = code;
            opcnt++;
         end
      end
      if (last) begin
         while (opcnt > 0) begin
            if (opstk[opcnt-1] != CODE_LPAREN)
               res.push_back('{GLYPH[opstk[opcnt-1]], 1'b0, ovf_seen});
            opcnt--;
         end
         res.push_back('{CHAR_NUL, 1'b1, ovf_seen});
         ovf_seen = 1'b0;
      end
   endfunction

   function automatic stim_type row(input logic [7:0] ch, input logic last);
      return '{ch, last, 1'b0, 1'b0, '0};
   endfunction

   function automatic stim_type row_fix(input logic [7:0] ch, input logic last,
                                        input logic nres,
                                        input logic [7:0] rch, input logic rlast);
      return '{ch, last, 1'b1, nres, '{rch, rlast, 1'b0}};
   endfunction

   function automatic logic [7:0] rand_operand();
      int k;
      k = $urandom_range(0, 61);
      if (k < 26) return CHAR_LO_A + 8'(k);
      if (k < 52) return CHAR_UP_A + 8'(k - 26);
      return CHAR_ZERO + 8'(k - 52);
   endfunction

   function automatic logic [7:0] rand_operator();
      case ($urandom_range(0, 4))
         0:       return CHAR_PLUS;
         1:       return CHAR_MINUS;
         2:       return CHAR_STAR;
         3:       return CHAR_SLASH;
         default: return CHAR_CARET;
      endcase
   endfunction

   task automatic build_expr(input int kind, input int span, input int style,
                             ref stim_type seq [$]);
      int depth;
      int n;
      seq = {};
      depth = 0;
      case (kind)
         EXPR_WELL: begin
            n = $urandom_range(1, 10);
            for (int i = 0; i < n; i++) begin
               while (depth < 6 && $urandom_range(0, 3) == 0) begin
                  seq.push_back(row(CHAR_LPAREN, 1'b0));
                  depth++;
               end
               seq.push_back(row(rand_operand(), 1'b0));
               while (depth > 0 && $urandom_range(0, 2) == 0) begin
                  seq.push_back(row(CHAR_RPAREN, 1'b0));
                  depth--;
               end
               if (i < n - 1) seq.push_back(row(rand_operator(), 1'b0));
               if ($urandom_range(0, 19) == 0)
                  seq.push_back(row(8'($urandom_range(0, 255)), 1'b0));
            end
            if ($urandom_range(0, 7) != 0) begin
               while (depth > 0) begin
                  seq.push_back(row(CHAR_RPAREN, 1'b0));
                  depth--;
               end
            end
            if ($urandom_range(0, 5) == 0)
               seq.push_back(row(8'($urandom_range(0, 255)), 1'b1));
         end
         EXPR_DEEP: begin
            if (style == DEEP_CARET) begin
               seq.push_back(row(rand_operand(), 1'b0));
               repeat (span) begin
                  seq.push_back(row(CHAR_CARET, 1'b0));
                  seq.push_back(row(rand_operand(), 1'b0));
               end
            end else begin
               repeat (span) begin
                  seq.push_back(row(CHAR_LPAREN, 1'b0));
                  seq.push_back(row(rand_operand(), 1'b0));
                  seq.push_back(row(rand_operator(), 1'b0));
               end
               seq.push_back(row(rand_operand(), 1'b0));
               repeat ($urandom_range(0, span)) seq.push_back(row(CHAR_RPAREN, 1'b0));
            end
         end
         default: begin
            n = $urandom_range(1, 16);
            repeat (n) begin
               case ($urandom_range(0, 4))
                  0:       seq.push_back(row(rand_operand(), 1'b0));
                  1:       seq.push_back(row(rand_operator(), 1'b0));
                  2:       seq.push_back(row(CHAR_LPAREN, 1'b0));
                  3:       seq.push_back(row(CHAR_RPAREN, 1'b0));
                  default: seq.push_back(row(8'($urandom_range(0, 255)), 1'b0));
               endcase
            end
         end
      endcase
      if (kind != EXPR_BROKEN || $urandom_range(0, 2) != 0) seq[seq.size()-1].last = 1'b1;
   endtask

   task automatic send_item(input stim_type it);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      cur_item <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
   endtask

   // receiver stall pattern, with one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rx_tick++;
         if (long_hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_cnt = HOLD_CYCLES;
         end
         if (rx_left == 0) begin
            rx_mode = $urandom_range(RX_FREE, RX_BEAT);
            rx_left = $urandom_range(20, 80);
         end
         rx_left--;
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_stall <= 1'b1;
         end else begin
            case (rx_mode)
               RX_FREE:  rsp_stall <= 1'b0;
               RX_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               RX_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
               default:  rsp_stall <= (rx_tick % 3 == 0);
            endcase
         end
      end
   end

   // result checking, then prediction for the item taken at this edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            chars_out++;
            if (rsp_out_last) exprs_done++;
            if (rsp_out_last && rsp_overflow) ovf_terms++;
            if (postfix_q.size() == 0) begin
               err_cnt++;
               if (err_cnt <= MAX_REPORTS)
                  $display("unexpected result: char %h last %b ovf %b",
                           rsp_out_char, rsp_out_last, rsp_overflow);
            end else begin
               want = postfix_q.pop_front();
               if (rsp_out_char !== want.ch || rsp_out_last !== want.last ||
                   rsp_overflow !== want.ovf) begin
                  err_cnt++;
                  if (err_cnt <= MAX_REPORTS)
                     $display({"mismatch: expected char %h last %b ovf %b, ",
                               "got char %h last %b ovf %b"},
                              want.ch, want.last, want.ovf,
                              rsp_out_char, rsp_out_last, rsp_overflow);
               end
            end
         end
         if (req_valid && !req_stall) begin
            items_in++;
            shunt_char(cur_item.ch, cur_item.last, step_res);
            if (cur_item.typed) begin
               step_res = {};
               if (cur_item.nres) step_res.push_back(cur_item.r);
            end
            foreach (step_res[k]) postfix_q.push_back(step_res[k]);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("infix_to_postfix_converter_core regression: fail");
         $finish;
      end
   end

   initial begin
      stim_type seq [$];
      int useful;
      dir_tab = '{
         row_fix(CHAR_LO_A, 1'b0, 1'b1, CHAR_LO_A, 1'b0),
         row(CHAR_PLUS, 1'b0),
         row("b", 1'b0),
         row(CHAR_STAR, 1'b0),
         row("c", 1'b0),
         row(CHAR_MINUS, 1'b0),
         row("d", 1'b0),
         row(CHAR_SLASH, 1'b0),
         row("e", 1'b0),
         row(CHAR_CARET, 1'b0),
         row("f", 1'b0),
         row(CHAR_CARET, 1'b0),
         row("g", 1'b1),
         row_fix(CHAR_LPAREN, 1'b0, 1'b0, CHAR_NUL, 1'b0),
         row_fix(CHAR_UP_Z, 1'b0, 1'b1, CHAR_UP_Z, 1'b0),
         row(CHAR_PLUS, 1'b0),
         row_fix(CHAR_NINE, 1'b0, 1'b1, CHAR_NINE, 1'b0),
         row(CHAR_RPAREN, 1'b0),
         row_fix(CHAR_RPAREN, 1'b0, 1'b0, CHAR_NUL, 1'b0),
         row_fix(8'hFF, 1'b0, 1'b0, CHAR_NUL, 1'b0),
         row_fix(CHAR_NUL, 1'b0, 1'b0, CHAR_NUL, 1'b0),
         row(CHAR_LPAREN, 1'b0),
         row(CHAR_ZERO, 1'b1),
         row_fix(CHAR_NUL, 1'b1, 1'b1, CHAR_NUL, 1'b1),
         row_fix(CHAR_LO_Z, 1'b0, 1'b1, CHAR_LO_Z, 1'b0),
         row(CHAR_UP_A, 1'b1)
      };
      useful = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i]) send_item(dir_tab[i]);

      // caret chain past the stack depth while the receiver holds off
      long_hold_req <= 1'b1;
      build_expr(EXPR_DEEP, 38, DEEP_CARET, seq);
      while (useful < RANDOM_ITEMS) begin
         foreach (seq[i]) begin
            send_item(seq[i]);
            if (seq[i].last || is_alnum(seq[i].ch) || op_of(seq[i].ch) != CODE_NONE ||
                seq[i].ch == CHAR_RPAREN) useful++;
         end
         case ($urandom_range(0, 9))
            0:       build_expr(EXPR_DEEP, $urandom_range(20, 40),
                                $urandom_range(DEEP_CARET, DEEP_NESTED), seq);
            1, 2:    build_expr(EXPR_BROKEN, 0, 0, seq);
            default: build_expr(EXPR_WELL, 0, 0, seq);
         endcase
      end
      req_valid <= 1'b0;

      while (postfix_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("items accepted %0d, postfix characters checked %0d, expressions terminated %0d",
               items_in, chars_out, exprs_done);
      $display("terminators flagging a dropped push %0d, receiver hold-off %0d cycles",
               ovf_terms, HOLD_CYCLES);
      if (err_cnt == 0 && postfix_q.size() == 0) begin
         $display("infix_to_postfix_converter_core regression: pass");
      end else begin
         $display("infix_to_postfix_converter_core regression: fail");
      end
      $finish;
   end

endmodule
